/* design/arpnp_pkg.sv */
// Package: shared types, constants and digit decode for the radix-prefix number parser.
package arpnp_pkg;

   // Width of the accumulated value; the result field is always OUT_WIDTH bits.
   localparam int VALUE_WIDTH = 64;
   localparam int OUT_WIDTH   = 64;
   localparam int CHAR_WIDTH  = 8;
   localparam int DIGIT_WIDTH = 5;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [CHAR_WIDTH-1:0] CHAR_LA    = 8'h61;  // 'a'
   localparam logic [CHAR_WIDTH-1:0] CHAR_LF    = 8'h66;  // 'f'
   localparam logic [CHAR_WIDTH-1:0] CHAR_UA    = 8'h41;  // 'A'
   localparam logic [CHAR_WIDTH-1:0] CHAR_UF    = 8'h46;  // 'F'
   localparam logic [CHAR_WIDTH-1:0] CHAR_X     = 8'h78;  // 'x'
   localparam logic [CHAR_WIDTH-1:0] CHAR_B     = 8'h62;  // 'b'

   // Digit value reported for a character that is no digit at all
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE = 5'd16;

   localparam logic [DIGIT_WIDTH-1:0] BASE_DEC = 5'd10;
   localparam logic [DIGIT_WIDTH-1:0] BASE_HEX = 5'd16;
   localparam logic [DIGIT_WIDTH-1:0] BASE_BIN = 5'd2;

   localparam logic [VALUE_WIDTH-1:0] VALUE_ALL_ONES = {VALUE_WIDTH{1'b1}};

   // Parser phase, one-hot
   typedef enum logic [3:0] {
      PH_FIRST  = 4'b0001,  // expecting first character
      PH_PREFIX = 4'b0010,  // saw leading '0', expecting prefix letter
      PH_DIGITS = 4'b0100,  // reading digits
      PH_SKIP   = 4'b1000   // error seen, dropping up to the last character
   } arpnp_phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2
   } arpnp_radix_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_PREFIX = 2'd1,
      ERR_DIGIT  = 2'd2
   } arpnp_err_type;

   typedef struct packed {
      arpnp_phase_type         phase;
      arpnp_radix_type         radix;
      logic [VALUE_WIDTH-1:0]  acc;
      arpnp_err_type           err;
   } arpnp_state_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] value;
      logic                 failed;
      arpnp_err_type        error_kind;
   } arpnp_result_type;

   // Value of a digit character, DIGIT_NONE for anything else
   function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
      logic [CHAR_WIDTH-1:0] d;
      d = CHAR_WIDTH'(DIGIT_NONE);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         d = c - CHAR_LA + 8'd10;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d = c - CHAR_UA + 8'd10;
      end
      return d[DIGIT_WIDTH-1:0];
   endfunction

endpackage

/* design/arpnp_req_if.sv */
// Interface: character input channel, one character and end mark per beat.
interface arpnp_req_if;
   import arpnp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] ch;
   logic                  last_char;

   modport source (output valid, output ch, output last_char, input ready);
   modport sink   (input valid, input ch, input last_char, output ready);
endinterface

/* design/arpnp_rsp_if.sv */
// Interface: parse result channel, one parsed number per beat.
interface arpnp_rsp_if;
   import arpnp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OUT_WIDTH-1:0] value;
   logic                 failed;
   logic [1:0]           error_kind;

   modport source (output valid, output value, output failed, output error_kind, input ready);
   modport sink   (input valid, input value, input failed, input error_kind, output ready);
endinterface

/* design/arpnp_step.sv */
// Module: next parser state and result for one character beat.
module arpnp_step (
   input  arpnp_pkg::arpnp_state_type  cur,
   input  logic [7:0]                  ch,
   input  logic                        last_char,
   output arpnp_pkg::arpnp_state_type  nxt,
   output arpnp_pkg::arpnp_result_type result
);
   import arpnp_pkg::*;

   arpnp_radix_type         radix_eff;
   logic [DIGIT_WIDTH-1:0]  digit;
   logic [DIGIT_WIDTH-1:0]  base;
   logic [VALUE_WIDTH-1:0]  digit_ext;
   logic [VALUE_WIDTH-1:0]  acc_scaled;
   logic                    digit_bad;
   logic                    take_digit;
   arpnp_state_type         walk;

   // First character always restarts in base ten
   assign radix_eff = (cur.phase == PH_FIRST) ? RADIX_DEC : cur.radix;
   assign digit     = digit_of(ch);
   assign digit_ext = VALUE_WIDTH'(digit);

   always_comb begin
      case (radix_eff)
         RADIX_HEX: base = BASE_HEX;
         RADIX_BIN: base = BASE_BIN;
         default:   base = BASE_DEC;
      endcase
   end

   assign digit_bad = (digit >= base);

   // Constant-base multiply: shifts and one add
   always_comb begin
      case (radix_eff)
         RADIX_HEX: acc_scaled = cur.acc << 4;
         RADIX_BIN: acc_scaled = cur.acc << 1;
         default:   acc_scaled = (cur.acc << 3) + (cur.acc << 1);
      endcase
   end

   // Phase walk
   always_comb begin
      walk       = cur;
      take_digit = 1'b0;
      unique case (cur.phase)
         PH_FIRST: begin
            if (ch == CHAR_ZERO && !last_char) begin
               walk.phase = PH_PREFIX;
            end else begin
               walk.radix = RADIX_DEC;
               take_digit = 1'b1;
            end
         end
         PH_PREFIX: begin
            if (ch == CHAR_X) begin
               walk.radix = RADIX_HEX;
               walk.phase = PH_DIGITS;
            end else if (ch == CHAR_B) begin
               walk.radix = RADIX_BIN;
               walk.phase = PH_DIGITS;
            end else begin
               walk.err   = ERR_PREFIX;
               walk.phase = PH_SKIP;
            end
         end
         PH_DIGITS: begin
            take_digit = 1'b1;
         end
         default: begin
         end
      endcase
      if (take_digit) begin
         if (digit_bad) begin
            walk.err   = ERR_DIGIT;
            walk.phase = PH_SKIP;
         end else begin
            walk.acc   = acc_scaled + digit_ext;
            walk.phase = PH_DIGITS;
         end
      end
   end

   // Result on the last character, then back to the start state
   always_comb begin
      if (walk.err != ERR_NONE) begin
         result.value      = OUT_WIDTH'(VALUE_ALL_ONES);
         result.failed     = 1'b1;
         result.error_kind = walk.err;
      end else begin
         result.value      = OUT_WIDTH'(walk.acc);
         result.failed     = 1'b0;
         result.error_kind = ERR_NONE;
      end
      if (last_char) begin
         nxt.phase = PH_FIRST;
         nxt.radix = RADIX_DEC;
         nxt.acc   = '0;
         nxt.err   = ERR_NONE;
      end else begin
         nxt = walk;
      end
   end

endmodule

/* design/ascii_radix_prefix_number_parser.sv */
// Top level: ASCII number parser with 0x/0b radix prefix, one character per beat.
//
//   channel    | dir | beat content                       | when
//   -----------+-----+------------------------------------+--------------------------
//   req_chan   | in  | ch, last_char                      | one beat per character
//   rsp_chan   | out | value, failed, error_kind          | one beat per last_char
//
// One character is taken every cycle while the pipeline is not stalled; the result of the
// beat that carries last_char passes the input register, then the result register.
// The parse step is one shift/add of the accumulator between the two registers.
// Reset clears the parser state and both valid flags; the next beat starts a new string.
// With rsp_chan stalled the result register holds, the input register fills,
// and req_chan.ready drops only when both are full.
module ascii_radix_prefix_number_parser (
   input  logic        clock,
   input  logic        reset,
   arpnp_req_if.sink   req_chan,
   arpnp_rsp_if.source rsp_chan
);
   import arpnp_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [CHAR_WIDTH-1:0] in_ch_ff;
   logic                  in_last_ff;
   arpnp_state_type       state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   arpnp_result_type      rsp_data_ff;
   arpnp_result_type      step_result;
   logic                  advance;
   logic                  req_take;

   // Pipeline moves whenever the result slot is empty or being taken
   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   arpnp_step u_step (
      .cur       (state_ff),
      .ch        (in_ch_ff),
      .last_char (in_last_ff),
      .nxt       (state_in),
      .result    (step_result)
   );

   // Input register
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_ch_ff   <= req_chan.ch;
         in_last_ff <= req_chan.last_char;
      end
   end

   // Parser state and result register
   assign rsp_valid_in = advance ? (in_valid_ff && in_last_ff) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= PH_FIRST;
         state_ff.radix <= RADIX_DEC;
         state_ff.acc   <= '0;
         state_ff.err   <= ERR_NONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (advance && in_valid_ff) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && in_valid_ff && in_last_ff) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.value      = rsp_data_ff.value;
   assign rsp_chan.failed     = rsp_data_ff.failed;
   assign rsp_chan.error_kind = rsp_data_ff.error_kind;

`ifndef ASSERT_OFF
   // A failed result carries the all-ones value
   a_fail_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.failed) |-> (rsp_data_ff.value == OUT_WIDTH'(VALUE_ALL_ONES)))
      else $error("failed result without all-ones value");

   // failed flag agrees with the error kind
   a_fail_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.failed == (rsp_data_ff.error_kind != ERR_NONE)))
      else $error("failed flag and error kind disagree");

   // A last character ends the string: state back to start, result posted
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && in_last_ff) |=> (state_ff.phase == PH_FIRST && rsp_valid_ff))
      else $error("last character did not post a result and restart");

   // A middle character never returns the parser to the start phase
   a_mid_no_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && !in_last_ff) |=> (state_ff.phase != PH_FIRST))
      else $error("middle character restarted the parser");
`endif

endmodule

/* sim/ascii_radix_prefix_number_parser_tb.sv */
// Testbench: random and directed character streams checked against a parser model.
module ascii_radix_prefix_number_parser_tb;
   import arpnp_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int QUIET_TAIL   = 150;   // final beats sent with no idling on either side
   localparam int RANDOM_BEATS = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_LIMIT  = 100;

   typedef struct {
      logic [CHAR_WIDTH-1:0] ch;
      logic                  last;
      bit                    hold;      // wait for all results before sending this beat
   } char_beat_type;

   logic clock = 1'b0;
   logic reset;

   arpnp_req_if req_chan ();
   arpnp_rsp_if rsp_chan ();

   ascii_radix_prefix_number_parser uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   char_beat_type    beat_queue[$];
   arpnp_result_type parsed_results[$];
   char_beat_type    beat;

   // Parser model state
   arpnp_phase_type        parse_phase = PH_FIRST;
   arpnp_radix_type        parse_radix = RADIX_DEC;
   logic [VALUE_WIDTH-1:0] parse_acc   = '0;
   arpnp_err_type          parse_err   = ERR_NONE;

   int mismatches = 0;
   int cycles     = 0;
   int send_gap   = 0;
   int recv_stall = 0;
   bit quiet      = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      // keep the log bounded when everything goes wrong
      if (mismatches <= PRINT_LIMIT) $display("%0t: mismatch: %s", $time, msg);
   endtask

   // Fold one digit character into the accumulator, or flag a bad digit
   task automatic take_char_digit(input logic [CHAR_WIDTH-1:0] c);
      int base;
      int digit;
      case (parse_radix)
         RADIX_HEX: base = 16;
         RADIX_BIN: base = 2;
         default:   base = 10;
      endcase
      if (c >= CHAR_ZERO && c <= CHAR_NINE)   digit = int'(c) - int'(CHAR_ZERO);
      else if (c >= CHAR_LA && c <= CHAR_LF)  digit = int'(c) - int'(CHAR_LA) + 10;
      else if (c >= CHAR_UA && c <= CHAR_UF)  digit = int'(c) - int'(CHAR_UA) + 10;
      else                                    digit = 16;
      if (digit >= base) begin
         parse_err   = ERR_DIGIT;
         parse_phase = PH_SKIP;
      end else begin
         parse_acc   = parse_acc * VALUE_WIDTH'(base) + VALUE_WIDTH'(digit);
         parse_phase = PH_DIGITS;
      end
   endtask

   // Advance the model by one accepted beat; queue the result on the last one
   task automatic advance_parser(input logic [CHAR_WIDTH-1:0] c, input logic last);
      arpnp_result_type res;
      case (parse_phase)
         PH_FIRST: begin
            if (c == CHAR_ZERO && !last) begin
               parse_phase = PH_PREFIX;
            end else begin
               parse_radix = RADIX_DEC;
               take_char_digit(c);
            end
         end
         PH_PREFIX: begin
            if (c == CHAR_X) begin
               parse_radix = RADIX_HEX;
               parse_phase = PH_DIGITS;
            end else if (c == CHAR_B) begin
               parse_radix = RADIX_BIN;
               parse_phase = PH_DIGITS;
            end else begin
               parse_err   = ERR_PREFIX;
               parse_phase = PH_SKIP;
            end
         end
         PH_DIGITS: take_char_digit(c);
         default: ;
      endcase
      if (last) begin
         if (parse_err != ERR_NONE) begin
            res.value      = OUT_WIDTH'(VALUE_ALL_ONES);
            res.failed     = 1'b1;
            res.error_kind = parse_err;
         end else begin
            res.value      = OUT_WIDTH'(parse_acc);
            res.failed     = 1'b0;
            res.error_kind = ERR_NONE;
         end
         parsed_results.push_back(res);
         parse_phase = PH_FIRST;
         parse_radix = RADIX_DEC;
         parse_acc   = '0;
         parse_err   = ERR_NONE;
      end
   endtask

   task automatic push_text(input string s, input bit hold);
      char_beat_type b;
      for (int i = 0; i < s.len(); i++) begin
         b.ch   = s[i];
         b.last = (i == s.len() - 1);
         b.hold = hold && (i == 0);
         beat_queue.push_back(b);
      end
   endtask

   // One random string: mostly well-formed numbers, some corrupted, some noise
   task automatic add_random_string();
      logic [CHAR_WIDTH-1:0] txt[$];
      char_beat_type b;
      int kind;
      int n;
      int k;
      bit hold;
      kind = $urandom_range(0, 19);
      hold = ($urandom_range(0, 59) == 0);
      if (kind < 5) begin
         // decimal, long ones wrap past 64 bits
         txt.push_back(CHAR_ZERO + CHAR_WIDTH'($urandom_range(1, 9)));
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(19, 26) : $urandom_range(0, 8);
         repeat (n) txt.push_back(CHAR_ZERO + CHAR_WIDTH'($urandom_range(0, 9)));
      end else if (kind < 9 || (kind >= 14 && kind < 17)) begin
         // hex with mixed case digits
         txt.push_back(CHAR_ZERO);
         txt.push_back(CHAR_X);
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 8);
         repeat (n) begin
            k = $urandom_range(0, 21);
            txt.push_back(k < 10 ? CHAR_ZERO + CHAR_WIDTH'(k) :
                          (k < 16 ? CHAR_LA + CHAR_WIDTH'(k - 10) :
                                    CHAR_UA + CHAR_WIDTH'(k - 16)));
         end
         // corrupted variant: one character replaced by any byte
         if (kind >= 14)
            txt[$urandom_range(0, txt.size() - 1)] = CHAR_WIDTH'($urandom_range(0, 255));
      end else if (kind < 12) begin
         txt.push_back(CHAR_ZERO);
         txt.push_back(CHAR_B);
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(62, 68) : $urandom_range(0, 12);
         repeat (n) txt.push_back(CHAR_ZERO + CHAR_WIDTH'($urandom_range(0, 1)));
      end else if (kind == 12) begin
         txt.push_back(CHAR_ZERO);
      end else if (kind == 13) begin
         txt.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
      end else begin
         // noise
         n = $urandom_range(1, 6);
         repeat (n) txt.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
      end
      foreach (txt[i]) begin
         b.ch   = txt[i];
         b.last = (i == txt.size() - 1);
         b.hold = hold && (i == 0);
         beat_queue.push_back(b);
      end
   endtask

   // Sender: one beat per handshake, random gaps until the quiet tail
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("ascii_radix_prefix_number_parser_tb failed");
         $finish;
      end
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) advance_parser(req_chan.ch, req_chan.last_char);
         quiet = (beat_queue.size() < QUIET_TAIL);
         if (req_chan.valid && !req_chan.ready) begin
            // hold the current beat
         end else if (send_gap != 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (beat_queue.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (beat_queue[0].hold && parsed_results.size() != 0) begin
            req_chan.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 14) - 1;
            req_chan.valid <= 1'b0;
         end else begin
            beat = beat_queue.pop_front();
            req_chan.valid     <= 1'b1;
            req_chan.ch        <= beat.ch;
            req_chan.last_char <= beat.last;
         end
      end
   end

   // Receiver: random stall bursts, check each result beat against the model
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (parsed_results.size() == 0) begin
               report_mismatch($sformatf("result with none expected: value=%h", rsp_chan.value));
            end else begin
               if (rsp_chan.value !== parsed_results[0].value)
                  report_mismatch($sformatf("value %h, expected %h",
                                            rsp_chan.value, parsed_results[0].value));
               if (rsp_chan.failed !== parsed_results[0].failed)
                  report_mismatch($sformatf("failed %b, expected %b",
                                            rsp_chan.failed, parsed_results[0].failed));
               if (rsp_chan.error_kind !== parsed_results[0].error_kind)
                  report_mismatch($sformatf("error_kind %0d, expected %0d",
                                            rsp_chan.error_kind, parsed_results[0].error_kind));
               void'(parsed_results.pop_front());
            end
         end
         if (recv_stall != 0) begin
            recv_stall--;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(1, 14) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.ch        = '0;
      req_chan.last_char = 1'b0;
      rsp_chan.ready     = 1'b0;

      // Directed strings: prefixes, lone zero, errors, skipped tail, byte extremes
      push_text("0", 1'b0);
      push_text("0x", 1'b1);
      push_text("0b", 1'b0);
      push_text("0q5", 1'b0);
      push_text("0X1", 1'b0);
      push_text("7", 1'b0);
      push_text("z", 1'b0);
      push_text("0b12", 1'b0);
      push_text("0xfF", 1'b0);
      push_text("9a", 1'b0);
      beat_queue.push_back('{ch: 8'h00, last: 1'b1, hold: 1'b0});
      beat_queue.push_back('{ch: 8'hFF, last: 1'b1, hold: 1'b0});

      while (beat_queue.size() < RANDOM_BEATS) add_random_string();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (beat_queue.size() != 0 || req_chan.valid || parsed_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      while (parsed_results.size() != 0) begin
         report_mismatch($sformatf("missing result: value=%h", parsed_results[0].value));
         void'(parsed_results.pop_front());
      end

      if (mismatches == 0) begin
         $display("ascii_radix_prefix_number_parser_tb passed");
      end else begin
         $display("ascii_radix_prefix_number_parser_tb failed");
      end
      $finish;
   end

endmodule
